@@ design/ras_pkg.sv @@
// ----------------------------------------------------------------------------
// ras_pkg: shared types and control store for the rational search block
// Holds the field widths, the control-word layout and the read-only program
// that sequences the Stern-Brocot datapath.
// ----------------------------------------------------------------------------
package ras_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = 16;
    localparam int VALUE_W    = 32;
    localparam int NUM_W      = 32;
    localparam int TOL_W      = 16;
    localparam int FRAC_W     = FRAC_BITS;
    localparam int WHOLE_W    = INT_BITS;
    localparam int DEN_W      = FRAC_BITS + 1;
    localparam int DIFF_W     = 35;
    localparam int MAG_W      = DIFF_W - 1;
    localparam int PROD_W     = TOL_W + DEN_W;
    localparam int SCALE_W    = WHOLE_W + DEN_W;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        STEP_LOAD  = 3'd0,
        STEP_MUL   = 3'd1,
        STEP_TEST  = 3'd2,
        STEP_SCALE = 3'd3,
        STEP_EMIT  = 3'd4
    } step_t;

    // Datapath action selected by a control word.
    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_MUL,
        ACT_MEDIANT,
        ACT_SCALE,
        ACT_EMIT
    } action_t;

    // Branch condition tested by a control word.
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_INPUT,
        COND_CLOSE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        action_t act;
        cond_t   cond;
        step_t   tgt_true;
        step_t   tgt_false;
    } ctrl_word_t;

    // Control store: one word per step.
    function automatic ctrl_word_t ctrl_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_LOAD:  w = '{ACT_LOAD,    COND_INPUT,    STEP_MUL,   STEP_LOAD};
            STEP_MUL:   w = '{ACT_MUL,     COND_ALWAYS,   STEP_TEST,  STEP_TEST};
            STEP_TEST:  w = '{ACT_MEDIANT, COND_CLOSE,    STEP_SCALE, STEP_MUL};
            STEP_SCALE: w = '{ACT_SCALE,   COND_ALWAYS,   STEP_EMIT,  STEP_EMIT};
            STEP_EMIT:  w = '{ACT_EMIT,    COND_OUT_FREE, STEP_LOAD,  STEP_EMIT};
            default:    w = '{ACT_LOAD,    COND_ALWAYS,   STEP_LOAD,  STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ design/rational_approximation_search.sv @@
// ----------------------------------------------------------------------------
// rational_approximation_search: best rational approximation of a Q16.16 value
// Splits the input into whole and fractional parts and walks the Stern-Brocot
// tree from 0/1 and 1/1 until the candidate lies within the tolerance.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (item_valid, item_ready, value) carries one unsigned
// Q16.16 number per transfer. The output channel (result_valid, result_ready,
// numerator, denominator, inexact) returns exactly one fraction per input.
// The tolerance register is written through cfg_we and cfg_wdata, in units of
// 2^-16, and must only be changed while the block is idle.
// Control comes from a five-step program in a small control store. A search
// takes one multiply step and one test step per candidate, after a load step
// for the item, and ends with a step that scales the whole part and one that
// writes the output register. The loop through the tolerance multiplier runs
// once per candidate; the number of mediant steps can reach 2^16 - 1 at worst.
// The result sits in an output register; the block goes back to accept the
// next item while that result waits, and only stalls its write-out step if
// the previous result has still not been taken.
// Reset clears the program counter, the output valid flag and the tolerance.
// ----------------------------------------------------------------------------
module rational_approximation_search
    import ras_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TOL_W-1:0]     cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [VALUE_W-1:0]   value,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [NUM_W-1:0]     numerator,
    output logic [DEN_W-1:0]     denominator,
    output logic                 inexact
);

    // Sequencer state.
    step_t            step_reg, step_next;
    ctrl_word_t       ctrl;
    logic             cond_true;

    logic [TOL_W-1:0] tol_reg;

    // Search datapath. Differences hold p*2^F - x*q in two's complement.
    logic [DEN_W-1:0]   low_num_reg,  low_num_next;
    logic [DEN_W-1:0]   low_den_reg,  low_den_next;
    logic [DEN_W-1:0]   high_num_reg, high_num_next;
    logic [DEN_W-1:0]   high_den_reg, high_den_next;
    logic [DIFF_W-1:0]  low_diff_reg, low_diff_next;
    logic [DIFF_W-1:0]  high_diff_reg, high_diff_next;
    logic [DEN_W-1:0]   cur_num_reg,  cur_num_next;
    logic [DEN_W-1:0]   cur_den_reg,  cur_den_next;
    logic [DIFF_W-1:0]  cur_diff_reg, cur_diff_next;
    logic [WHOLE_W-1:0] whole_reg,    whole_next;
    logic [PROD_W-1:0]  prod_reg,     prod_next;
    logic [MAG_W-1:0]   mag_reg,      mag_next;
    logic [SCALE_W-1:0] scale_reg,    scale_next;

    // Output register.
    logic               result_valid_reg, result_valid_next;
    logic [NUM_W-1:0]   numerator_reg,    numerator_next;
    logic [DEN_W-1:0]   denominator_reg,  denominator_next;
    logic               inexact_reg,      inexact_next;

    logic [FRAC_W-1:0]  frac_in;
    logic [DEN_W-1:0]   med_num;
    logic [DEN_W-1:0]   med_den;
    logic [DIFF_W-1:0]  med_diff;
    logic               med_not_pos;
    logic [DIFF_W-1:0]  cur_mag;
    logic               close_enough;
    logic               out_free;

    assign ctrl = ctrl_rom(step_reg);

    assign frac_in = value[FRAC_W-1:0];

    // Mediant of the two bounds, with its difference formed by one addition.
    assign med_num     = low_num_reg + high_num_reg;
    assign med_den     = low_den_reg + high_den_reg;
    assign med_diff    = low_diff_reg + high_diff_reg;
    assign med_not_pos = med_diff[DIFF_W-1] || (med_diff == '0);

    assign cur_mag      = cur_diff_reg[DIFF_W-1] ? (DIFF_W'(0) - cur_diff_reg) : cur_diff_reg;
    assign close_enough = mag_reg <= MAG_W'(prod_reg);
    assign out_free     = !result_valid_reg || result_ready;

    // Branch condition of the current control word.
    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_INPUT:    cond_true = item_valid;
            COND_CLOSE:    cond_true = close_enough;
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b1;
        endcase
    end

    // Next step of the program.
    always_comb
    begin
        step_next = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
    end

    // Input-side ready decoded from the control word.
    always_comb
    begin
        item_ready = (ctrl.act == ACT_LOAD);
    end

    // Datapath actions.
    always_comb
    begin
        low_num_next      = low_num_reg;
        low_den_next      = low_den_reg;
        high_num_next     = high_num_reg;
        high_den_next     = high_den_reg;
        low_diff_next     = low_diff_reg;
        high_diff_next    = high_diff_reg;
        cur_num_next      = cur_num_reg;
        cur_den_next      = cur_den_reg;
        cur_diff_next     = cur_diff_reg;
        whole_next        = whole_reg;
        prod_next         = prod_reg;
        mag_next          = mag_reg;
        scale_next        = scale_reg;
        numerator_next    = numerator_reg;
        denominator_next  = denominator_reg;
        inexact_next      = inexact_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (ctrl.act)
            ACT_LOAD:
            begin
                // Start from the bounds 0/1 and 1/1 with candidate 0/1.
                if (item_valid)
                begin
                    whole_next     = value[FRAC_BITS +: WHOLE_W];
                    low_num_next   = '0;
                    low_den_next   = DEN_W'(1);
                    high_num_next  = DEN_W'(1);
                    high_den_next  = DEN_W'(1);
                    low_diff_next  = DIFF_W'(0) - DIFF_W'(frac_in);
                    high_diff_next = (DIFF_W'(1) << FRAC_BITS) - DIFF_W'(frac_in);
                    cur_num_next   = '0;
                    cur_den_next   = DEN_W'(1);
                    cur_diff_next  = DIFF_W'(0) - DIFF_W'(frac_in);
                end
            end
            ACT_MUL:
            begin
                prod_next = PROD_W'(tol_reg) * PROD_W'(cur_den_reg);
                mag_next  = cur_mag[MAG_W-1:0];
            end
            ACT_MEDIANT:
            begin
                // Only step the tree while the candidate is still too far off.
                if (!close_enough)
                begin
                    if (med_not_pos)
                    begin
                        low_num_next  = med_num;
                        low_den_next  = med_den;
                        low_diff_next = med_diff;
                    end
                    else
                    begin
                        high_num_next  = med_num;
                        high_den_next  = med_den;
                        high_diff_next = med_diff;
                    end
                    cur_num_next  = med_num;
                    cur_den_next  = med_den;
                    cur_diff_next = med_diff;
                end
            end
            ACT_SCALE:
            begin
                scale_next = SCALE_W'(whole_reg) * SCALE_W'(cur_den_reg);
            end
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    numerator_next    = scale_reg[NUM_W-1:0] + NUM_W'(cur_num_reg);
                    denominator_next  = cur_den_reg;
                    inexact_next      = (cur_diff_reg != '0);
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_LOAD;
            result_valid_reg <= 1'b0;
            tol_reg          <= '0;
        end
        else
        begin
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        low_num_reg     <= low_num_next;
        low_den_reg     <= low_den_next;
        high_num_reg    <= high_num_next;
        high_den_reg    <= high_den_next;
        low_diff_reg    <= low_diff_next;
        high_diff_reg   <= high_diff_next;
        cur_num_reg     <= cur_num_next;
        cur_den_reg     <= cur_den_next;
        cur_diff_reg    <= cur_diff_next;
        whole_reg       <= whole_next;
        prod_reg        <= prod_next;
        mag_reg         <= mag_next;
        scale_reg       <= scale_next;
        numerator_reg   <= numerator_next;
        denominator_reg <= denominator_next;
        inexact_reg     <= inexact_next;
    end

    assign result_valid = result_valid_reg;
    assign numerator    = numerator_reg;
    assign denominator  = denominator_reg;
    assign inexact      = inexact_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for rational_approximation_search
// Sends Q16.16 values through the input handshake, takes each fraction from
// a table or a Stern-Brocot walk of its own and compares every returned
// numerator, denominator and inexact flag in order. A directed table comes
// first, then random values under several tolerance settings and idling mixes.
// ----------------------------------------------------------------------------
module testbench
    import ras_pkg::*;
();

    // One returned fraction, field for field as the output ports carry it.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             inexact;
    } fraction_t;

    // One row of the directed table. When known_valid is set, the expected
    // fraction is typed in by hand; otherwise the predictor supplies it.
    typedef struct {
        logic [TOL_W-1:0]   tol;
        logic [VALUE_W-1:0] value;
        bit                 known_valid;
        fraction_t          known;
    } probe_t;

    localparam int N_PROBES      = 23;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 13;
    // Random draws whose walk would run longer than this are redrawn, so the
    // run stays short. The directed table covers the longest walks.
    localparam int MAX_RANDOM_STEPS = 1500;
    // Cycles allowed after the last transfer, and before a tolerance write.
    localparam int SETTLE_CYCLES = 16;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [TOL_W-1:0]    cfg_wdata = '0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [VALUE_W-1:0]  value = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [NUM_W-1:0]    numerator;
    logic [DEN_W-1:0]    denominator;
    logic                inexact;

    // Fractions predicted for accepted values, oldest first.
    fraction_t        pending_fractions[$];
    logic [TOL_W-1:0] active_tolerance = '0;
    int               failures = 0;
    // Idle chances in percent for the sending and the receiving side.
    int               send_idle = 0;
    int               recv_idle = 0;

    // Directed table: extremes of the value and of the tolerance, the zero
    // fraction, a mediant that hits the fraction exactly, the longest walks
    // (fraction one ulp above zero and one ulp below one), and tolerances
    // large enough that the starting candidate 0/1 already passes.
    probe_t directed_probes [0:N_PROBES-1] = '{
        '{16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 17'd1,     1'b0}},
        '{16'h0000, 32'hFFFF_0000, 1'b1, '{32'h0000_FFFF, 17'd1,     1'b0}},
        '{16'h0000, 32'h0000_8000, 1'b1, '{32'h0000_0001, 17'd2,     1'b0}},
        '{16'h0000, 32'h0001_8000, 1'b1, '{32'h0000_0003, 17'd2,     1'b0}},
        '{16'h0000, 32'h0000_4000, 1'b1, '{32'h0000_0001, 17'd4,     1'b0}},
        '{16'h0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 17'd65536, 1'b0}},
        '{16'h0000, 32'h0000_FFFF, 1'b1, '{32'h0000_FFFF, 17'd65536, 1'b0}},
        '{16'h0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 17'd65536, 1'b0}},
        '{16'h0000, 32'h0000_5555, 1'b0, '0},
        '{16'h0000, 32'hAAAA_AAAA, 1'b0, '0},
        '{16'h0000, 32'h3243_F6A8, 1'b0, '0},
        '{16'hFFFF, 32'h1234_5678, 1'b1, '{32'h0000_1234, 17'd1,     1'b1}},
        '{16'hFFFF, 32'h0000_FFFF, 1'b1, '{32'h0000_0000, 17'd1,     1'b1}},
        '{16'hFFFF, 32'h0007_0000, 1'b1, '{32'h0000_0007, 17'd1,     1'b0}},
        '{16'hFFFF, 32'h5555_5555, 1'b1, '{32'h0000_5555, 17'd1,     1'b1}},
        '{16'h0001, 32'h0000_0001, 1'b1, '{32'h0000_0000, 17'd1,     1'b1}},
        '{16'h0001, 32'h0000_5555, 1'b0, '0},
        '{16'h0001, 32'h0000_8001, 1'b0, '0},
        '{16'h0001, 32'h0000_FFFE, 1'b0, '0},
        '{16'h0100, 32'h0002_B7E1, 1'b0, '0},
        '{16'h0100, 32'hCAFE_1357, 1'b0, '0},
        '{16'h8000, 32'h0000_8000, 1'b1, '{32'h0000_0000, 17'd1,     1'b1}},
        '{16'h8000, 32'h0003_8001, 1'b0, '0}
    };

    rational_approximation_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .numerator    (numerator),
        .denominator  (denominator),
        .inexact      (inexact)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A hard stop far beyond the slowest correct run: three walks of 2^16 - 1
    // mediant steps, plus every other item at its own step bound, all stretched
    // by the idling of both sides.
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stern-Brocot walk over the fraction part. Each bound keeps the signed
    // difference p*2^F - x*q, so the mediant's difference is the sum of the
    // two, and the stop test |d| <= tol*q needs no division. The number of
    // mediant steps is returned as well, to keep random walks short.
    function automatic fraction_t best_fraction(input logic [VALUE_W-1:0] v,
                                                input logic [TOL_W-1:0] tol,
                                                output int unsigned steps);
        logic [FRAC_W-1:0]        frac;
        logic [WHOLE_W-1:0]       whole;
        logic [DEN_W-1:0]         lo_p, lo_q, hi_p, hi_q, p, q, m_p, m_q;
        logic signed [DIFF_W-1:0] lo_d, hi_d, d, m_d;
        logic [MAG_W-1:0]         mag_d;
        logic [SCALE_W-1:0]       scaled;
        fraction_t                r;
        frac  = v[FRAC_W-1:0];
        whole = v[FRAC_W +: WHOLE_W];
        lo_p  = '0;
        lo_q  = DEN_W'(1);
        hi_p  = DEN_W'(1);
        hi_q  = DEN_W'(1);
        lo_d  = DIFF_W'(0) - DIFF_W'(frac);
        hi_d  = (DIFF_W'(1) << FRAC_BITS) - DIFF_W'(frac);
        p     = lo_p;
        q     = lo_q;
        d     = lo_d;
        steps = 0;
        mag_d = (d < 0) ? MAG_W'(-d) : MAG_W'(d);
        while (mag_d > PROD_W'(tol) * PROD_W'(q))
        begin
            m_p = lo_p + hi_p;
            m_q = lo_q + hi_q;
            m_d = lo_d + hi_d;
            // A mediant at or below the target becomes the new lower bound.
            if (m_d <= 0)
            begin
                lo_p = m_p;
                lo_q = m_q;
                lo_d = m_d;
            end
            else
            begin
                hi_p = m_p;
                hi_q = m_q;
                hi_d = m_d;
            end
            p = m_p;
            q = m_q;
            d = m_d;
            steps++;
            mag_d = (d < 0) ? MAG_W'(-d) : MAG_W'(d);
        end
        // The whole part is folded back in; it wraps at the numerator width.
        scaled    = SCALE_W'(whole) * SCALE_W'(q) + SCALE_W'(p);
        r.num     = scaled[NUM_W-1:0];
        r.den     = q;
        r.inexact = (d != 0);
        return r;
    endfunction

    // Random values lean toward the shapes that stress the walk: fractions
    // of zero, dyadic fractions with few bits, and fractions close to either
    // end of the unit interval, besides plain random words.
    function automatic logic [VALUE_W-1:0] random_value();
        int                kind;
        logic [FRAC_W-1:0] frac;
        kind = $urandom_range(0, 9);
        case (kind)
            6:       frac = '0;
            7:       frac = FRAC_W'($urandom_range(1, 255)) << $urandom_range(0, 8);
            8:       frac = FRAC_W'($urandom_range(1, 255));
            9:       frac = FRAC_W'(16'hFFFF - $urandom_range(0, 255));
            default: return VALUE_W'($urandom);
        endcase
        return {WHOLE_W'($urandom), frac};
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        failures++;
    endtask

    // Offers one value on the input channel and files its expected fraction
    // once the transfer happens. The valid line is only lowered for idle
    // cycles, so back-to-back values keep it high throughout.
    task automatic send_value(input logic [VALUE_W-1:0] v, input fraction_t want);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        do
            @(posedge clk);
        while (!item_ready);
        pending_fractions.push_back(want);
    endtask

    // The tolerance is only rewritten once the block has returned every
    // fraction and has had time to settle back to its idle step.
    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        item_valid <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we           <= 1'b0;
        active_tolerance  = tol;
    endtask

    // Output side: every transfer is checked against the oldest prediction,
    // and the ready line is redrawn at each edge from the receive idle rate.
    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_fractions.size() == 0)
            begin
                report_failure($sformatf("result %0d/%0d with nothing pending",
                                         numerator, denominator));
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (numerator !== want.num)
                    report_failure($sformatf("numerator %0d, expected %0d",
                                             numerator, want.num));
                if (denominator !== want.den)
                    report_failure($sformatf("denominator %0d, expected %0d",
                                             denominator, want.den));
                if (inexact !== want.inexact)
                    report_failure($sformatf("inexact %0b, expected %0b",
                                             inexact, want.inexact));
            end
        end
        result_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Stimulus: reset, the directed table, then three idling mixes with two
    // tolerance settings each, and finally the drain.
    initial
    begin
        logic [TOL_W-1:0]   tol;
        logic [VALUE_W-1:0] v;
        fraction_t          want;
        int unsigned        steps;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The sender idles now and then while the receiver holds back often.
        send_idle = 23;
        recv_idle = 60;

        for (int i = 0; i < N_PROBES; i++)
        begin
            if (i == 0 || directed_probes[i].tol != active_tolerance)
                set_tolerance(directed_probes[i].tol);
            if (directed_probes[i].known_valid)
                want = directed_probes[i].known;
            else
                want = best_fraction(directed_probes[i].value, active_tolerance, steps);
            send_value(directed_probes[i].value, want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // Idling mixes: the directed mix first, then the two rates swapped,
            // then both sides at full speed.
            if (phase == 2)
            begin
                send_idle = 60;
                recv_idle = 23;
            end
            else if (phase == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            // Exact search, 1 to 63 ulps of slack, and anything up to the maximum.
            case (phase % 3)
                0:       tol = '0;
                1:       tol = TOL_W'($urandom_range(1, 63));
                default: tol = TOL_W'($urandom);
            endcase
            set_tolerance(tol);
            repeat (PHASE_ITEMS)
            begin
                do
                begin
                    v    = random_value();
                    want = best_fraction(v, active_tolerance, steps);
                end
                while (steps > MAX_RANDOM_STEPS);
                send_value(v, want);
            end
        end

        item_valid <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
        // A stray extra result would show up during the settle wait.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
